### sv/tcs_pkg.sv
`timescale 1ns / 1ps

package tcs_pkg;

  // Default screen geometry.
  localparam int unsigned ColumnsDef = 80;
  localparam int unsigned RowsDef    = 25;

  localparam logic [7:0] BlankChar   = 8'h20;
  localparam logic [7:0] NewlineChar = 8'h0A;
  localparam logic [7:0] ResetAttr   = 8'h0F;

  typedef enum logic [1:0] {
    CMD_PUT       = 2'd0,
    CMD_BACKSPACE = 2'd1,
    CMD_CLEAR     = 2'd2,
    CMD_READ      = 2'd3
  } tcs_cmd_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_FILL,
    S_SCROLL,
    S_DRAIN,
    S_DONE
  } tcs_state_e;

  typedef struct packed {
    tcs_cmd_e    cmd;
    logic [7:0]  ch;
    logic [4:0]  read_row;
    logic [6:0]  read_col;
  } tcs_in_t;

  typedef struct packed {
    logic [10:0] cursor_pos;
    logic [15:0] cell_value;
  } tcs_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic exec;
    logic fill_init;
    logic fill_clear;
    logic scroll_step;
    logic load_out;
  } tcs_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    tcs_cmd_e cmd;
    logic     scroll_needed;
    logic     sweep_last;
  } tcs_stat_t;

endpackage

### sv/tcs_datapath.sv
`timescale 1ns / 1ps

module tcs_datapath #(
  parameter int unsigned COLUMNS = tcs_pkg::ColumnsDef,
  parameter int unsigned ROWS    = tcs_pkg::RowsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tcs_pkg::tcs_ctrl_t ctrl_i,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_data_i,
  input  tcs_pkg::tcs_in_t   in_item_i,
  output tcs_pkg::tcs_stat_t stat_o,
  output tcs_pkg::tcs_out_t  out_item_o
);

  localparam int unsigned Cells      = COLUMNS * ROWS;
  localparam int unsigned CopyCells  = (ROWS - 1) * COLUMNS;
  localparam int unsigned AW         = $clog2(Cells);
  localparam int unsigned CW         = $clog2(COLUMNS);
  localparam int unsigned RW         = $clog2(ROWS);

  logic [15:0]       mem [Cells];
  logic [15:0]       rdata_q;

  tcs_pkg::tcs_in_t  item_q;
  tcs_pkg::tcs_out_t out_item_q;
  logic [7:0]        attr_q;
  logic [CW-1:0]     col_q, col_d;
  logic [RW-1:0]     row_q, row_d;
  logic [AW-1:0]     cnt_q, cnt_d;
  logic              pipe_valid_q, pipe_valid_d;
  logic              pipe_copy_q;
  logic [AW-1:0]     pipe_addr_q;
  logic              hit_q;

  logic [AW-1:0]     cur_pos;
  logic [AW-1:0]     bs_pos;
  logic [AW-1:0]     rd_cell_addr;
  logic [31:0]       pos_wide;
  logic              rd_hit;
  logic              is_newline;
  logic              col_last;
  logic              row_last;
  logic              sweep_last;
  logic              copy_phase;

  logic              re;
  logic [AW-1:0]     raddr;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [15:0]       wdata;

  assign cur_pos      = AW'(row_q) * AW'(COLUMNS) + AW'(col_q);
  assign bs_pos       = (cur_pos == '0) ? '0 : cur_pos - AW'(1);
  assign rd_cell_addr = AW'(item_q.read_row) * AW'(COLUMNS) + AW'(item_q.read_col);
  assign pos_wide     = 32'(cur_pos);
  assign rd_hit       = (32'(item_q.read_row) < ROWS) && (32'(item_q.read_col) < COLUMNS);
  assign is_newline   = (item_q.ch == tcs_pkg::NewlineChar);
  assign col_last     = (col_q == CW'(COLUMNS - 1));
  assign row_last     = (row_q == RW'(ROWS - 1));
  assign sweep_last   = (cnt_q == AW'(Cells - 1));
  assign copy_phase   = (32'(cnt_q) < CopyCells);

  assign stat_o.cmd           = item_q.cmd;
  assign stat_o.scroll_needed = (item_q.cmd == tcs_pkg::CMD_PUT) && row_last &&
                                (is_newline || col_last);
  assign stat_o.sweep_last    = sweep_last;

  // Cursor update and sweep counter.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (ctrl_i.exec) begin
      case (item_q.cmd)
        tcs_pkg::CMD_PUT: begin
          if (is_newline || col_last) begin
            col_d = '0;
            if (!row_last) begin
              row_d = row_q + RW'(1);
            end
          end else begin
            col_d = col_q + CW'(1);
          end
        end
        tcs_pkg::CMD_BACKSPACE: begin
          if (col_q != '0) begin
            col_d = col_q - CW'(1);
          end else if (row_q != '0) begin
            col_d = CW'(COLUMNS - 1);
            row_d = row_q - RW'(1);
          end
        end
        tcs_pkg::CMD_CLEAR: begin
          col_d = '0;
          row_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (ctrl_i.fill_init || ctrl_i.fill_clear || ctrl_i.scroll_step) begin
      cnt_d = sweep_last ? '0 : cnt_q + AW'(1);
    end
  end

  assign pipe_valid_d = ctrl_i.scroll_step;

  // Memory port selection: one read and one write per cycle.
  always_comb begin
    re    = 1'b0;
    raddr = rd_cell_addr;
    if (ctrl_i.exec && item_q.cmd == tcs_pkg::CMD_READ && rd_hit) begin
      re = 1'b1;
    end else if (ctrl_i.scroll_step && copy_phase) begin
      re    = 1'b1;
      raddr = AW'(32'(cnt_q) + COLUMNS);
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = cnt_q;
    wdata = {attr_q, tcs_pkg::BlankChar};
    if (pipe_valid_q) begin
      we    = 1'b1;
      waddr = pipe_addr_q;
      wdata = pipe_copy_q ? rdata_q : {attr_q, tcs_pkg::BlankChar};
    end else if (ctrl_i.fill_init) begin
      we    = 1'b1;
      wdata = {tcs_pkg::ResetAttr, tcs_pkg::BlankChar};
    end else if (ctrl_i.fill_clear) begin
      we = 1'b1;
    end else if (ctrl_i.exec && item_q.cmd == tcs_pkg::CMD_PUT && !is_newline) begin
      we    = 1'b1;
      waddr = cur_pos;
      wdata = {attr_q, item_q.ch};
    end else if (ctrl_i.exec && item_q.cmd == tcs_pkg::CMD_BACKSPACE) begin
      we    = 1'b1;
      waddr = bs_pos;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q       <= tcs_pkg::ResetAttr;
      col_q        <= '0;
      row_q        <= '0;
      cnt_q        <= '0;
      pipe_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        attr_q <= cfg_data_i;
      end
      col_q        <= col_d;
      row_q        <= row_d;
      cnt_q        <= cnt_d;
      pipe_valid_q <= pipe_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_item) begin
      item_q <= in_item_i;
    end
    if (ctrl_i.exec) begin
      hit_q <= (item_q.cmd == tcs_pkg::CMD_READ) && rd_hit;
    end
    if (ctrl_i.scroll_step) begin
      pipe_addr_q <= cnt_q;
      pipe_copy_q <= copy_phase;
    end
    if (ctrl_i.load_out) begin
      out_item_q.cursor_pos <= pos_wide[10:0];
      out_item_q.cell_value <= hit_q ? rdata_q : 16'h0000;
    end
  end

  assign out_item_o = out_item_q;

`ifndef SYNTH
  a_cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(row_q) < ROWS) && (32'(col_q) < COLUMNS))
    else $error("cursor left the screen");
`endif

endmodule

### sv/tcs_ctrl.sv
`timescale 1ns / 1ps

module tcs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  tcs_pkg::tcs_stat_t stat_i,
  output tcs_pkg::tcs_ctrl_t ctrl_o
);

  tcs_pkg::tcs_state_e state_q, state_d;
  logic                out_valid_q, out_valid_d;
  logic                out_free;
  logic                accept;

  assign out_free = !out_valid_q || !out_stall_i;
  assign accept   = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      tcs_pkg::S_INIT: begin
        if (stat_i.sweep_last) begin
          state_d = tcs_pkg::S_IDLE;
        end
      end
      tcs_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = tcs_pkg::S_EXEC;
        end
      end
      tcs_pkg::S_EXEC: begin
        if (stat_i.cmd == tcs_pkg::CMD_CLEAR) begin
          state_d = tcs_pkg::S_FILL;
        end else if (stat_i.scroll_needed) begin
          state_d = tcs_pkg::S_SCROLL;
        end else begin
          state_d = tcs_pkg::S_DONE;
        end
      end
      tcs_pkg::S_FILL: begin
        if (stat_i.sweep_last) begin
          state_d = tcs_pkg::S_DONE;
        end
      end
      tcs_pkg::S_SCROLL: begin
        if (stat_i.sweep_last) begin
          state_d = tcs_pkg::S_DRAIN;
        end
      end
      tcs_pkg::S_DRAIN: begin
        state_d = tcs_pkg::S_DONE;
      end
      tcs_pkg::S_DONE: begin
        if (out_free) begin
          state_d = in_valid_i ? tcs_pkg::S_EXEC : tcs_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = tcs_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl_o     = '0;
    in_stall_o = 1'b1;
    case (state_q)
      tcs_pkg::S_INIT: begin
        ctrl_o.fill_init = 1'b1;
      end
      tcs_pkg::S_IDLE: begin
        in_stall_o       = 1'b0;
        ctrl_o.load_item = in_valid_i;
      end
      tcs_pkg::S_EXEC: begin
        ctrl_o.exec = 1'b1;
      end
      tcs_pkg::S_FILL: begin
        ctrl_o.fill_clear = 1'b1;
      end
      tcs_pkg::S_SCROLL: begin
        ctrl_o.scroll_step = 1'b1;
      end
      tcs_pkg::S_DONE: begin
        in_stall_o       = !out_free;
        ctrl_o.load_out  = out_free;
        ctrl_o.load_item = out_free && in_valid_i;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcs_pkg::S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == tcs_pkg::S_EXEC)
    else $error("accepted item did not start execution");

  a_sweep_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tcs_pkg::S_INIT || state_q == tcs_pkg::S_FILL ||
     state_q == tcs_pkg::S_SCROLL || state_q == tcs_pkg::S_DRAIN) |-> in_stall_o)
    else $error("item accepted during a store sweep");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == tcs_pkg::S_DONE)
    else $error("result raised outside the done state");
`endif

endmodule

### sv/text_terminal_cursor_scroll_core.sv
`timescale 1ns / 1ps

// Character-cell text terminal engine with a COLUMNS x ROWS screen store
// (80 x 25 by default) of 16-bit cells, attribute in the high byte and
// character in the low byte. Each item carries a command: put a character
// (newline moves to the next line), backspace, clear the screen, or read one
// cell. Every item returns exactly one result holding the linear cursor
// position after the command and, for a read, the cell contents. Put,
// backspace and read pass through an execute and a done state, and the next
// item is taken in the done state as the result is loaded unless the output
// is stalled; a put that runs past the last row scrolls the screen. A scroll
// or a clear walks the whole store because the cell memory has one write
// port and is updated one cell per cycle. After reset the block clears the
// store to spaces with attribute 0x0F, one cell per cycle, and holds
// in_stall_o high until that pass ends.
// The attribute register may be written at any time the block is idle.

module text_terminal_cursor_scroll_core #(
  parameter int unsigned COLUMNS = tcs_pkg::ColumnsDef,
  parameter int unsigned ROWS    = tcs_pkg::RowsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Command items.
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tcs_pkg::tcs_in_t  in_item_i,
  // Result items.
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tcs_pkg::tcs_out_t out_item_o,
  // Attribute register write.
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_data_i
);

  // The controller sequences each item; the datapath owns the cursor,
  // the attribute register, the cell memory and the result register.
  tcs_pkg::tcs_ctrl_t ctrl;
  tcs_pkg::tcs_stat_t stat;

  tcs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  tcs_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_item_i  (in_item_i),
    .stat_o     (stat),
    .out_item_o (out_item_o)
  );

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import tcs_pkg::*;

  // Screen geometry of the default build.
  localparam int Cols = ColumnsDef;
  localparam int Rows = RowsDef;
  localparam int Slots = Cols * Rows;

  // Random part: eight attribute settings, one batch of commands under each.
  localparam int NumPhases = 8;
  localparam int ItemsPerPhase = 244;

  // A scroll or a clear walks the whole store, and so does the clearing pass
  // after reset. Output stalls add to the wait on top of that.
  localparam int unsigned QuietLimit = 20000;
  localparam int SettleCycles = 8;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  tcs_in_t in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  tcs_out_t out_item_o;
  logic cfg_we_i = 1'b0;
  logic [7:0] cfg_data_i = 8'h00;

  text_terminal_cursor_scroll_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Shadow copy of the terminal: screen contents, cursor and attribute register.
  logic [15:0] screen_image [Slots];
  int cur_row;
  int cur_col;
  logic [7:0] attr_reg;

  // Commands waiting to be driven and results waiting to be seen.
  tcs_in_t cmd_backlog [$];
  tcs_out_t expected_results [$];

  int unsigned issued_count = 0;
  int unsigned accepted_count = 0;
  int unsigned results_seen = 0;
  int unsigned fail_count = 0;
  int unsigned n_puts = 0;
  int unsigned n_newlines = 0;
  int unsigned n_backspaces = 0;
  int unsigned n_clears = 0;
  int unsigned n_reads = 0;
  int unsigned n_scrolls = 0;
  int unsigned n_attr_writes = 0;

  // When set, neither side inserts gaps, so items stream back to back.
  bit steady = 1'b0;

  int unsigned in_gap = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;

  wire in_fire  = in_valid_i && !in_stall_o;
  wire out_fire = out_valid_o && !out_stall_i;

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // Applies one command to the shadow terminal and returns the result it yields.
  function automatic tcs_out_t apply_terminal_cmd(tcs_in_t c);
    tcs_out_t res;
    res = '0;
    case (c.cmd)
      CMD_PUT: begin
        n_puts++;
        if (c.ch == NewlineChar) begin
          n_newlines++;
          cur_col = 0;
          cur_row++;
        end else begin
          screen_image[cur_row * Cols + cur_col] = {attr_reg, c.ch};
          cur_col++;
        end
        if (cur_col >= Cols) begin
          cur_col = 0;
          cur_row++;
        end
        // Running off the bottom shifts every row up and blanks the last one.
        if (cur_row >= Rows) begin
          n_scrolls++;
          for (int k = 0; k < (Rows - 1) * Cols; k++) begin
            screen_image[k] = screen_image[k + Cols];
          end
          for (int k = 0; k < Cols; k++) begin
            screen_image[(Rows - 1) * Cols + k] = {attr_reg, BlankChar};
          end
          cur_row = Rows - 1;
        end
      end
      CMD_BACKSPACE: begin
        n_backspaces++;
        // At home the cursor stays put; the home cell is still blanked.
        if (cur_col > 0) begin
          cur_col--;
        end else if (cur_row > 0) begin
          cur_col = Cols - 1;
          cur_row--;
        end
        screen_image[cur_row * Cols + cur_col] = {attr_reg, BlankChar};
      end
      CMD_CLEAR: begin
        n_clears++;
        for (int k = 0; k < Slots; k++) begin
          screen_image[k] = {attr_reg, BlankChar};
        end
        cur_row = 0;
        cur_col = 0;
      end
      CMD_READ: begin
        n_reads++;
        // A read off the screen returns zero and changes nothing.
        if (int'(c.read_row) < Rows && int'(c.read_col) < Cols) begin
          res.cell_value = screen_image[int'(c.read_row) * Cols + int'(c.read_col)];
        end
      end
    endcase
    res.cursor_pos = 11'(cur_row * Cols + cur_col);
    return res;
  endfunction

  function automatic void push_cmd(tcs_cmd_e op, logic [7:0] ch, logic [4:0] row,
                                   logic [6:0] col);
    tcs_in_t it;
    it.cmd = op;
    it.ch = ch;
    it.read_row = row;
    it.read_col = col;
    cmd_backlog.push_back(it);
    issued_count++;
  endfunction

  // One random command. Text-heavy batches type long runs with newlines, so the
  // cursor reaches the bottom and scrolls; edit batches lean on backspace and reads.
  // Fields that a command does not use carry random noise.
  function automatic tcs_in_t random_command(bit text_heavy);
    tcs_in_t it;
    int unsigned r;
    int unsigned put_lim;
    int unsigned bs_lim;
    it.cmd = CMD_READ;
    it.ch = 8'($urandom);
    it.read_row = 5'($urandom);
    it.read_col = 7'($urandom);
    put_lim = text_heavy ? 700 : 450;
    bs_lim = text_heavy ? 800 : 650;
    r = $urandom_range(0, 999);
    if (r < put_lim) begin
      it.cmd = CMD_PUT;
      if ($urandom_range(0, 99) < (text_heavy ? 6 : 3)) it.ch = NewlineChar;
    end else if (r < bs_lim) begin
      it.cmd = CMD_BACKSPACE;
    end else if (r < bs_lim + 12) begin
      it.cmd = CMD_CLEAR;
    end else begin
      it.cmd = CMD_READ;
      // Most reads land on the screen, with the bottom row favored since text
      // collects there after scrolling; the rest use the full field range.
      if ($urandom_range(0, 9) != 0) begin
        if ($urandom_range(0, 3) == 0) begin
          it.read_row = 5'(Rows - 1);
        end else begin
          it.read_row = 5'($urandom_range(0, Rows - 1));
        end
        it.read_col = 7'($urandom_range(0, Cols - 1));
      end
    end
    return it;
  endfunction

  // Waits until every issued command has been accepted and answered, then lets
  // the block settle back to idle.
  task automatic wait_idle();
    while (accepted_count != issued_count || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_attribute(input logic [7:0] value);
    wait_idle();
    cfg_data_i <= value;
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    attr_reg = value;
    n_attr_writes++;
  endtask

  // Driver: presents the next command once the previous one has been taken,
  // after a random gap. A stalled command is held unchanged.
  always @(posedge clk_i or negedge rst_ni) begin : drive_commands
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i <= '0;
      in_gap <= 0;
    end else begin
      if (in_fire) begin
        expected_results.push_back(apply_terminal_cmd(in_item_i));
        accepted_count++;
      end
      if (!in_valid_i || in_fire) begin
        if (in_gap != 0) begin
          in_valid_i <= 1'b0;
          in_gap <= in_gap - 1;
        end else if (cmd_backlog.size() != 0) begin
          in_item_i <= cmd_backlog.pop_front();
          in_valid_i <= 1'b1;
          in_gap <= draw_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest prediction and
  // stalls the result side at random.
  always @(posedge clk_i or negedge rst_ni) begin : check_results
    tcs_out_t want;
    int unsigned gap;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_fire) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          if (fail_count < 10) begin
            $display("unexpected result: cursor_pos %0d cell_value %h",
                     out_item_o.cursor_pos, out_item_o.cell_value);
          end
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_item_o.cursor_pos !== want.cursor_pos ||
              out_item_o.cell_value !== want.cell_value) begin
            if (fail_count < 10) begin
              $display("result %0d: cursor_pos exp %0d got %0d, cell_value exp %h got %h",
                       results_seen, want.cursor_pos, out_item_o.cursor_pos,
                       want.cell_value, out_item_o.cell_value);
            end
            fail_count++;
          end
        end
      end
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        gap = draw_gap();
        out_stall_i <= (gap != 0);
        stall_left <= (gap != 0) ? gap - 1 : 0;
      end
    end
  end

  // Watchdog: a long stretch with no item moving on either side means a hang.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_fire || out_fire) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QuietLimit) begin
        $display("no progress for %0d cycles", QuietLimit);
        $display("CHECK FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    logic [7:0] attr_plan [NumPhases];
    for (int k = 0; k < Slots; k++) screen_image[k] = {ResetAttr, BlankChar};
    cur_row = 0;
    cur_col = 0;
    attr_reg = ResetAttr;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, under the reset attribute. It starts with a read of the
    // reset blank, then byte extremes, off-screen reads on each axis, backspace
    // across a line start and backspace at home after a clear.
    push_cmd(CMD_READ, 8'h00, 5'd0, 7'd0);
    push_cmd(CMD_PUT, 8'h00, 5'd31, 7'd127);
    push_cmd(CMD_PUT, 8'hFF, 5'd0, 7'd0);
    push_cmd(CMD_PUT, 8'h41, 5'd31, 7'd0);
    push_cmd(CMD_READ, 8'hFF, 5'd0, 7'd0);
    push_cmd(CMD_READ, 8'h00, 5'd0, 7'd2);
    push_cmd(CMD_BACKSPACE, 8'hFF, 5'd31, 7'd127);
    push_cmd(CMD_READ, 8'h00, 5'd0, 7'd2);
    push_cmd(CMD_READ, 8'h00, 5'd31, 7'd127);
    push_cmd(CMD_READ, 8'h00, 5'(Rows), 7'd0);
    push_cmd(CMD_READ, 8'h00, 5'd0, 7'(Cols));
    push_cmd(CMD_READ, 8'h00, 5'(Rows - 1), 7'(Cols - 1));
    push_cmd(CMD_PUT, NewlineChar, 5'd0, 7'd0);
    push_cmd(CMD_BACKSPACE, 8'h00, 5'd0, 7'd0);
    push_cmd(CMD_BACKSPACE, 8'h00, 5'd0, 7'd0);
    push_cmd(CMD_READ, 8'h00, 5'd0, 7'(Cols - 2));
    push_cmd(CMD_CLEAR, 8'hFF, 5'd31, 7'd127);
    push_cmd(CMD_BACKSPACE, 8'h00, 5'd0, 7'd0);
    push_cmd(CMD_READ, 8'h00, 5'd0, 7'd0);
    push_cmd(CMD_PUT, 8'h7F, 5'd0, 7'd0);
    push_cmd(CMD_PUT, 8'h80, 5'd0, 7'd0);
    push_cmd(CMD_READ, 8'h00, 5'd0, 7'd1);

    // Attribute settings for the random batches: both extremes, the reset
    // value, two fixed patterns and random values in between.
    attr_plan[0] = 8'h00;
    attr_plan[1] = 8'hFF;
    attr_plan[2] = 8'(($urandom_range(1, 254)));
    attr_plan[3] = ResetAttr;
    attr_plan[4] = 8'hA5;
    attr_plan[5] = 8'(($urandom_range(1, 254)));
    attr_plan[6] = 8'h5A;
    attr_plan[7] = 8'(($urandom_range(1, 254)));

    for (int p = 0; p < NumPhases; p++) begin
      set_attribute(attr_plan[p]);
      steady = (p % 3 == 2);
      for (int k = 0; k < ItemsPerPhase; k++) begin
        cmd_backlog.push_back(random_command(p % 2 == 0));
        issued_count++;
      end
    end
    wait_idle();

    if (expected_results.size() != 0) begin
      $display("%0d predicted results never arrived", expected_results.size());
      fail_count += expected_results.size();
    end

    $display("Ran %0d commands (%0d puts, %0d newlines, %0d backspaces, %0d clears, %0d reads)",
             accepted_count, n_puts, n_newlines, n_backspaces, n_clears, n_reads);
    $display("Checked %0d results over %0d scrolls and %0d attribute writes; %0d failures",
             results_seen, n_scrolls, n_attr_writes, fail_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### sim.f
sv/tcs_pkg.sv
sv/tcs_datapath.sv
sv/tcs_ctrl.sv
sv/text_terminal_cursor_scroll_core.sv
tb/testbench.sv
